FILE: rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned BytesW = 27;
  localparam int unsigned BsW    = 17;
  localparam int unsigned StatW  = 3;
  localparam int unsigned TblW   = 8;
  localparam int unsigned DivQW  = 32;

  localparam logic [StatW-1:0] ST_OK    = 3'd0;
  localparam logic [StatW-1:0] ST_ZERO  = 3'd1;
  localparam logic [StatW-1:0] ST_NOFIT = 3'd2;
  localparam logic [StatW-1:0] ST_NULL  = 3'd3;
  localparam logic [StatW-1:0] ST_RANGE = 3'd4;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_BSIZE = 2'd1;
  localparam logic [1:0] CFG_TABLE = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/bba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AW-1:0]          waddr_i,
  input  wire logic [WIDTH-1:0]       wdata_i,
  input  wire logic                   re_i,
  input  wire logic [AW-1:0]          raddr_i,
  output logic      [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bba_div.sv
// Restoring divider, one quotient bit per cycle (32-bit dividend, 17-bit divisor).
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_div
  import bba_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DivQW-1:0] dividend_i,
  input  wire logic [BsW-1:0]   divisor_i,
  output logic                  done_o,
  output logic [DivQW-1:0]      quot_o,
  output logic [BsW-1:0]        rem_o
);
  logic             busy_q;
  logic [5:0]       cnt_q;
  logic [DivQW-1:0] quot_q;
  logic [BsW-1:0]   rem_q;
  logic [BsW:0]     trial;
  logic             fits;

  assign trial  = {rem_q, quot_q[DivQW-1]};
  assign fits   = trial >= {1'b0, divisor_i};
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DivQW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? BsW'(trial - {1'b0, divisor_i}) : trial[BsW-1:0];
      quot_q <= {quot_q[DivQW-2:0], fits};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_q)
    else $error("divider done while still busy");
endmodule
`default_nettype wire

FILE: rtl/bitmap_block_allocator_top.sv
// Bitmap block allocator top level: command FSM, bitmap RAM, divider, multiplier.
// Depends on bba_pkg, bba_ram, bba_div.
`timescale 1ns / 1ps
`default_nettype none
// One command word is taken when start_i is high and busy_o is low; its result word
// appears on done_o for one cycle and cannot be held off. After reset the bitmap RAM is
// cleared one byte per cycle (busy_o high). An allocate runs one division and two
// multiplies, then scans the bitmap with one RAM read and eight bit steps per byte
// scanned, then marks each byte with a read and a write. A free runs two divisions,
// then clears each bitmap byte with a read and a write. The scan, over the RAM's single
// read port, sets the allocate time.
module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned MAX_TABLE_BYTES = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              kind_i,
  input  wire logic [BytesW-1:0] byte_count_i,
  input  wire logic [AddrW-1:0]  address_i,
  input  wire logic              address_present_i,
  output logic                   done_o,
  output logic [StatW-1:0]       status_o,
  output logic [AddrW-1:0]       granted_address_o,
  output logic [BytesW-1:0]      granted_bytes_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [AddrW-1:0]  cfg_wdata_i
);
  localparam int unsigned AW = (MAX_TABLE_BYTES > 1) ? $clog2(MAX_TABLE_BYTES) : 1;
  localparam int unsigned BW = $clog2(MAX_TABLE_BYTES * 8 + 1);
  localparam int unsigned PW = BytesW + BsW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV_NEED, S_CHK_NEED, S_SCAN_RD, S_SCAN_BIT,
    S_MUL_A, S_MUL_B, S_MUL_C, S_FREE_CHK, S_DIV_OFF, S_DIV_CNT,
    S_UPD_RD, S_UPD_WR
  } state_e;

  state_e              state_q;
  logic [AddrW-1:0]    base_q;
  logic [BsW-1:0]      bsize_q;
  logic [TblW-1:0]     tbl_q;
  logic [AW-1:0]       clr_q;
  logic [BytesW-1:0]   count_q;
  logic [BytesW-1:0]   need_q;
  logic [AddrW-1:0]    off_q;
  logic [BW-1:0]       blk_q;
  logic [BW-1:0]       run_q;
  logic [BW-1:0]       lo_q;
  logic [BW-1:0]       hi_q;
  logic                set_q;
  logic [PW-1:0]       prod_q;
  logic                div_go_q;
  logic [DivQW-1:0]    div_dvd_q;
  logic [StatW-1:0]    res_stat_q;
  logic [AddrW-1:0]    res_addr_q;
  logic [BytesW-1:0]   res_bytes_q;

  logic [BsW-1:0]      bs_eff;
  logic [15:0]         tb16;
  logic [15:0]         tb_sel;
  logic [BW-1:0]       nblk;
  logic [BytesW-1:0]   mul_a;
  logic [PW-1:0]       mul_p;
  logic                div_done;
  logic [DivQW-1:0]    div_q;
  logic [BsW-1:0]      div_r;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;
  logic [BW-1:0]       cur_blk;
  logic                cur_used;
  logic [BW-1:0]       new_run;
  logic [7:0]          upd_mask;
  logic [BW-1:0]       mask_blk [8];
  logic [BytesW:0]     stop_sum;

  assign bs_eff = (bsize_q == '0) ? BsW'(1) : bsize_q;
  assign tb16   = {8'd0, tbl_q};
  assign tb_sel = (tb16 > 16'(MAX_TABLE_BYTES)) ? 16'(MAX_TABLE_BYTES) : tb16;
  assign nblk   = BW'({tb_sel, 3'b000});
  assign mul_p  = PW'(mul_a) * PW'(bs_eff);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    unique case (state_q)
      S_MUL_A:    mul_a = BytesW'(blk_q);
      S_MUL_B:    mul_a = need_q;
      default:    mul_a = BytesW'(nblk);
    endcase
  end

  assign cur_blk  = blk_q - BW'(1);
  assign cur_used = ram_rdata[3'd7 - cur_blk[2:0]];
  assign new_run  = cur_used ? '0 : run_q + BW'(1);
  assign stop_sum = (BytesW + 1)'(lo_q) + (BytesW + 1)'(div_q[BytesW-1:0]);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask_blk[i] = {lo_q[BW-1:3], 3'(i)};
      upd_mask[7-i] = (mask_blk[i] >= lo_q) && (mask_blk[i] < hi_q);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(lo_q >> 3);
    ram_wdata = set_q ? (ram_rdata | upd_mask) : (ram_rdata & ~upd_mask);
    ram_re    = 1'b0;
    ram_raddr = AW'(lo_q >> 3);
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_SCAN_RD: begin
        ram_re    = (blk_q != '0);
        ram_raddr = AW'(cur_blk >> 3);
      end
      S_UPD_RD: ram_re = (lo_q < hi_q);
      S_UPD_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  bba_ram #(.WIDTH(8), .DEPTH(MAX_TABLE_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (bs_eff),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bsize_q <= BsW'(64);
      tbl_q   <= TblW'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE:  base_q  <= cfg_wdata_i;
        CFG_BSIZE: bsize_q <= cfg_wdata_i[BsW-1:0];
        CFG_TABLE: tbl_q   <= cfg_wdata_i[TblW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      done_o   <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      done_o   <= 1'b0;
      div_go_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_TABLE_BYTES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            count_q     <= byte_count_i;
            res_stat_q  <= ST_OK;
            res_addr_q  <= '0;
            res_bytes_q <= '0;
            if (kind_i == KIND_ALLOC) begin
              if (byte_count_i == '0) begin
                res_stat_q <= ST_ZERO;
                done_o     <= 1'b1;
              end else begin
                div_go_q  <= 1'b1;
                div_dvd_q <= DivQW'(byte_count_i);
                state_q   <= S_DIV_NEED;
              end
            end else if (!address_present_i) begin
              res_stat_q <= ST_NULL;
              done_o     <= 1'b1;
            end else if (address_i < base_q) begin
              res_stat_q <= ST_RANGE;
              done_o     <= 1'b1;
            end else begin
              off_q   <= address_i - base_q;
              prod_q  <= mul_p;
              state_q <= S_FREE_CHK;
            end
          end
        end
        S_DIV_NEED: begin
          if (div_done) begin
            need_q  <= div_q[BytesW-1:0] + BytesW'(div_r != '0);
            state_q <= S_CHK_NEED;
          end
        end
        S_CHK_NEED: begin
          blk_q <= nblk;
          run_q <= '0;
          if (need_q > BytesW'(nblk)) begin
            res_stat_q  <= ST_NOFIT;
            res_bytes_q <= count_q;
            done_o      <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (blk_q == '0) begin
            res_stat_q  <= ST_NOFIT;
            res_bytes_q <= count_q;
            done_o      <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_SCAN_BIT;
          end
        end
        S_SCAN_BIT: begin
          run_q <= new_run;
          blk_q <= cur_blk;
          if (BytesW'(new_run) == need_q) begin
            state_q <= S_MUL_A;
          end else if (cur_blk[2:0] == 3'd0) begin
            state_q <= S_SCAN_RD;
          end
        end
        S_MUL_A: begin
          prod_q  <= mul_p;
          lo_q    <= blk_q;
          hi_q    <= blk_q + BW'(need_q);
          set_q   <= 1'b1;
          state_q <= S_MUL_B;
        end
        S_MUL_B: begin
          res_addr_q <= base_q + prod_q[AddrW-1:0];
          prod_q     <= mul_p;
          state_q    <= S_MUL_C;
        end
        S_MUL_C: begin
          res_bytes_q <= prod_q[BytesW-1:0];
          state_q     <= S_UPD_RD;
        end
        S_FREE_CHK: begin
          if (PW'(off_q) > prod_q) begin
            res_stat_q <= ST_RANGE;
            done_o     <= 1'b1;
            state_q    <= S_IDLE;
          end else begin
            div_go_q  <= 1'b1;
            div_dvd_q <= off_q;
            state_q   <= S_DIV_OFF;
          end
        end
        S_DIV_OFF: begin
          if (div_done) begin
            lo_q      <= div_q[BW-1:0];
            div_go_q  <= 1'b1;
            div_dvd_q <= DivQW'(count_q);
            state_q   <= S_DIV_CNT;
          end
        end
        S_DIV_CNT: begin
          if (div_done) begin
            hi_q    <= (stop_sum > (BytesW + 1)'(nblk)) ? nblk : stop_sum[BW-1:0];
            set_q   <= 1'b0;
            state_q <= S_UPD_RD;
          end
        end
        S_UPD_RD: begin
          if (lo_q < hi_q) begin
            state_q <= S_UPD_WR;
          end else begin
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_UPD_WR: begin
          lo_q    <= {lo_q[BW-1:3] + (BW - 3)'(1), 3'b000};
          state_q <= S_UPD_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o          = res_stat_q;
  assign granted_address_o = res_addr_q;
  assign granted_bytes_o   = res_bytes_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_ZERO || status_o == ST_NOFIT ||
                status_o == ST_NULL || status_o == ST_RANGE))
    else $error("bad status code");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (granted_address_o == '0))
    else $error("address returned on failure");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD_WR) |-> $past(ram_re))
    else $error("bitmap write without read");
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for bitmap_block_allocator_top: directed and random allocate/free
// words, predicted by a bit-level bitmap allocator kept in the bench. Depends on bba_pkg, bitmap_block_allocator_top.
`timescale 1ns / 1ps
module tb_top;
  import bba_pkg::*;

  localparam int unsigned MAXT = 128;
  localparam int unsigned WDOG_LIMIT = 60000;

  typedef struct {
    logic              kind;
    logic [BytesW-1:0] cnt;
    logic [AddrW-1:0]  addr;
    logic              pres;
  } cmd_t;

  typedef struct {
    logic [StatW-1:0]  st;
    logic [AddrW-1:0]  ga;
    logic [BytesW-1:0] gb;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic kind_i = KIND_ALLOC;
  logic [BytesW-1:0] byte_count_i = '0;
  logic [AddrW-1:0] address_i = '0;
  logic address_present_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = CFG_BASE;
  logic [AddrW-1:0] cfg_wdata_i = '0;
  logic busy_o, done_o;
  logic [StatW-1:0] status_o;
  logic [AddrW-1:0] granted_address_o;
  logic [BytesW-1:0] granted_bytes_o;

  bitmap_block_allocator_top #(.MAX_TABLE_BYTES(MAXT)) u_dut (.*);

  always #10 clk_i = ~clk_i;

  // bench copy of allocator state
  logic [7:0] used_map [MAXT];
  logic [AddrW-1:0] pool_base = '0;
  logic [BsW-1:0] blk_bytes = 17'd64;
  logic [TblW-1:0] map_bytes = 8'd128;

  cmd_t pend_words[$];
  res_t want_words[$];
  res_t live_grants[$];
  int unsigned idle_pct = 33;
  int unsigned errs = 0;
  int unsigned stat_seen [5];
  int unsigned n_words = 0;
  int unsigned quiet = 0;
  bit took = 1'b0;

  function automatic res_t alloc_or_free(cmd_t c);
    res_t r;
    int unsigned bs, nblk, need, run, b, k;
    longint unsigned off, pool, first, last;
    bit found;
    r.st = ST_OK;
    r.ga = '0;
    r.gb = '0;
    bs = (blk_bytes == 0) ? 1 : blk_bytes;
    nblk = ((map_bytes > MAXT) ? MAXT : map_bytes) * 8;
    if (c.kind == KIND_ALLOC) begin
      if (c.cnt == 0) begin
        r.st = ST_ZERO;
      end else begin
        need = (c.cnt + bs - 1) / bs;
        run = 0;
        b = nblk;
        found = 1'b0;
        while (b > 0 && need <= nblk && !found) begin
          b--;
          if (used_map[b >> 3][7 - (b & 7)]) run = 0;
          else run++;
          if (run == need) found = 1'b1;
        end
        if (found) begin
          for (k = 0; k < need; k++) used_map[(b + k) >> 3][7 - ((b + k) & 7)] = 1'b1;
          r.ga = AddrW'(longint'(pool_base) + longint'(b) * bs);
          r.gb = BytesW'(longint'(need) * bs);
        end else begin
          r.st = ST_NOFIT;
          r.gb = c.cnt;
        end
      end
    end else if (!c.pres) begin
      r.st = ST_NULL;
    end else if (c.addr < pool_base) begin
      r.st = ST_RANGE;
    end else begin
      off = c.addr - pool_base;
      pool = longint'(nblk) * bs;
      if (off > pool) begin
        r.st = ST_RANGE;
      end else begin
        first = off / bs;
        last = first + c.cnt / bs;
        if (last > nblk) last = nblk;
        for (longint unsigned i = first; i < last; i++) used_map[i >> 3][7 - (i & 7)] = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h want %0h (word %0d)", what, got, want, n_words);
    errs++;
  endtask

  // driver: hold the word until taken
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !took)) begin
      if (pend_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start_i <= 1'b1;
        kind_i <= pend_words[0].kind;
        byte_count_i <= pend_words[0].cnt;
        address_i <= pend_words[0].addr;
        address_present_i <= pend_words[0].pres;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check on done, apply config writes
  always @(posedge clk_i) begin
    res_t r, w;
    took = rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      quiet++;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE:  pool_base = cfg_wdata_i;
          CFG_BSIZE: blk_bytes = cfg_wdata_i[BsW-1:0];
          CFG_TABLE: map_bytes = cfg_wdata_i[TblW-1:0];
          default: ;
        endcase
      end
      if (took) begin
        quiet = 0;
        r = alloc_or_free(pend_words.pop_front());
        want_words.push_back(r);
        if (r.st == ST_OK && r.gb != 0) live_grants.push_back(r);
      end
      if (done_o) begin
        quiet = 0;
        n_words++;
        if (want_words.size() == 0) begin
          report("unexpected result", 32'(status_o), 32'd0);
        end else begin
          w = want_words.pop_front();
          if (w.st < 5) stat_seen[w.st]++;
          if (status_o !== w.st) report("status", 32'(status_o), 32'(w.st));
          if (granted_address_o !== w.ga) report("granted_address", granted_address_o, w.ga);
          if (granted_bytes_o !== w.gb)
            report("granted_bytes", 32'(granted_bytes_o), 32'(w.gb));
        end
      end
      if (quiet >= WDOG_LIMIT) begin
        $display("watchdog: no handshake in %0d cycles", WDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic put(logic k, logic [BytesW-1:0] c, logic [AddrW-1:0] a, logic p);
    cmd_t w;
    w.kind = k;
    w.cnt = c;
    w.addr = a;
    w.pres = p;
    pend_words.push_back(w);
  endtask

  task automatic drain();
    while (pend_words.size() != 0 || want_words.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [AddrW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic rand_word();
    int unsigned pick, bs, j;
    res_t g;
    bs = (blk_bytes == 0) ? 1 : blk_bytes;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      put(KIND_ALLOC, BytesW'($urandom_range(1, 8 * bs)), $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 80 && live_grants.size() > 0) begin
      j = $urandom_range(0, live_grants.size() - 1);
      g = live_grants[j];
      live_grants.delete(j);
      if ($urandom_range(0, 3) == 0) g.gb = g.gb / 2;
      put(KIND_FREE, g.gb, g.ga, 1'b1);
    end else if (pick < 86) begin
      put(KIND_ALLOC, BytesW'($urandom), $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 92) begin
      put(KIND_FREE, BytesW'($urandom), $urandom, 1'($urandom_range(0, 1)));
    end else begin
      put(1'($urandom_range(0, 1)), '0, pool_base + $urandom_range(0, 4 * bs),
          1'($urandom_range(0, 1)));
    end
  endtask

  logic [AddrW-1:0] ph_base [6] = '{32'h0, 32'hFFFF_FFC0, 32'h1234_5000, 32'h0000_1000,
                                    32'h8000_0000, 32'h0000_0040};
  logic [AddrW-1:0] ph_bs [6] = '{32'd64, 32'd1, 32'd65536, 32'd0, 32'h1FFFF, 32'd48};
  logic [AddrW-1:0] ph_tb [6] = '{32'd128, 32'd1, 32'd255, 32'd0, 32'd16, 32'd4};

  initial begin
    int unsigned done_rand;
    for (int i = 0; i < MAXT; i++) used_map[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: base 0, 64-byte blocks, 1024 blocks
    put(KIND_ALLOC, 27'd0, 32'h0, 1'b1);
    put(KIND_ALLOC, 27'd1, 32'h0, 1'b0);
    put(KIND_ALLOC, 27'd64, 32'h0, 1'b1);
    put(KIND_ALLOC, 27'd65, 32'h0, 1'b1);
    put(KIND_ALLOC, 27'h7FF_FFFF, 32'hFFFF_FFFF, 1'b1);
    put(KIND_FREE, 27'd64, 32'hFFFF_FFFF, 1'b0);
    put(KIND_FREE, 27'd64, 32'd65536, 1'b1);
    put(KIND_FREE, 27'd64, 32'd65537, 1'b1);
    put(KIND_FREE, 27'd63, 32'd65472, 1'b1);
    put(KIND_FREE, 27'h7FF_FFFF, 32'd65472, 1'b1);
    put(KIND_FREE, 27'd67108864, 32'd0, 1'b1);
    put(KIND_ALLOC, 27'd65536, 32'h0, 1'b1);
    put(KIND_ALLOC, 27'd1, 32'h0, 1'b1);
    put(KIND_FREE, 27'd65536, 32'd0, 1'b1);
    put(KIND_ALLOC, 27'd65537, 32'h0, 1'b1);
    put(KIND_ALLOC, 27'd200, 32'h0, 1'b1);
    drain();

    done_rand = 0;
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_BASE, ph_base[ph]);
      cfg_write(CFG_BSIZE, ph_bs[ph]);
      cfg_write(CFG_TABLE, ph_tb[ph]);
      if (ph_base[ph] != 0) put(KIND_FREE, 27'd64, ph_base[ph] - 1, 1'b1);
      for (int n = 0; n < 80; n++) begin
        idle_pct = (done_rand < 160) ? 33 : (done_rand < 320) ? 74 : 0;
        rand_word();
        done_rand++;
        if (n % 8 == 7) drain();
      end
      drain();
      live_grants.delete();
    end

    drain();
    repeat (40) @(negedge clk_i);
    $display("ran %0d words over 7 settings: ok %0d, zero %0d, no fit %0d, null %0d, range %0d",
             n_words, stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4]);
    if (errs == 0 && want_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errs, want_words.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: bitmap_block_allocator_top.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_div.sv
rtl/bitmap_block_allocator_top.sv
bench/tb_top.sv
